// ----- rtl/fpa_pkg.sv -----
// shared types and constants for the fixed-point alu
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_MIN = 3'd4,
        MODE_MAX = 3'd5,
        MODE_INC = 3'd6,
        MODE_DEC = 3'd7
    } t_mode;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_SAT  = 2'd1;
    localparam logic [1:0] FAULT_DIV0 = 2'd2;

    localparam int DataW = 32;

    // per-item control carried alongside the data
    typedef struct packed {
        t_mode       mode;
        logic        a_less;
        logic        a_equal;
        logic        a_greater;
        logic        b_zero;
        logic        neg;
        logic [31:0] simple;
        logic [1:0]  simple_fault;
    } t_ctrl;
endpackage
`default_nettype wire

// ----- rtl/fpa_div.sv -----
// pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module fpa_div #(
    parameter int NumW = 48,
    parameter int DenW = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_adv,
    input  wire logic [NumW-1:0] i_num,
    input  wire logic [DenW-1:0] i_den,
    output logic      [NumW-1:0] o_quo
);
    // stage s holds partial remainder, shifted numerator, quotient bits
    logic [DenW:0]   r_rem [1:NumW];
    logic [NumW-1:0] r_num [1:NumW];
    logic [NumW-1:0] r_quo [1:NumW];
    logic [DenW-1:0] r_den [1:NumW];

    for (genvar s = 0; s < NumW; s++) begin : g_stage
        logic [DenW:0]   w_rem_in;
        logic [NumW-1:0] w_num_in;
        logic [NumW-1:0] w_quo_in;
        logic [DenW-1:0] w_den_in;
        logic [DenW+1:0] w_try;
        logic [DenW+1:0] w_sub;

        // first stage takes the inputs, later stages the previous registers
        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_num_in = i_num;
            assign w_quo_in = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[s];
            assign w_num_in = r_num[s];
            assign w_quo_in = r_quo[s];
            assign w_den_in = r_den[s];
        end

        assign w_try = {w_rem_in, w_num_in[NumW-1]};
        assign w_sub = w_try - {2'b00, w_den_in};
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[s+1] <= w_sub[DenW+1] ? w_try[DenW:0] : w_sub[DenW:0];
                r_quo[s+1] <= {w_quo_in[NumW-2:0], ~w_sub[DenW+1]};
                r_num[s+1] <= {w_num_in[NumW-2:0], 1'b0};
                r_den[s+1] <= w_den_in;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_quo <= r_quo[NumW];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/fixed_point_alu.sv -----
// fixed-point alu top level
// Signed fixed-point ALU on 32-bit raw values with FRACTION_BITS fraction bits.
// Input channel: i_valid with i_mode, i_operand_a, i_operand_b; o_stall back.
// Output channel: o_valid with o_result, flags and o_fault; i_stall back.
// A transfer happens at a clock edge with valid high and stall low.
// Every item, whatever its mode, walks the same pipeline so results leave
// in order. From the input transfer to o_valid an item passes the operand
// register, the bit-per-stage quotient array with its output register, then
// the saturate/select output register. Throughput is one item per cycle
// while the pipeline is not stalled; the divider array sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// empty slots ahead of the output are not squeezed out while it holds.
// Reset (i_rst_n low, synchronous) clears all valid bits; data is not reset.
// Multiply is exact 64-bit product in two 32x16 partial products, truncated
// toward zero; divide truncates toward zero; both saturate with fault 1.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_result,
    output logic             o_a_less,
    output logic             o_a_equal,
    output logic             o_a_greater,
    output logic [1:0]       o_fault
);
    localparam int NumW  = 32 + FRACTION_BITS;

    // global advance: pipeline moves unless output holds a blocked result
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // stage 0: operand decode
    fpa_pkg::t_ctrl  n_ctrl;
    logic [NumW-1:0] n_num;
    logic [31:0]     n_den;
    logic [31:0]     w_add, w_sub, w_abs_a, w_abs_b;
    logic [32:0]     w_add_x, w_sub_x;
    logic signed [31:0] w_sa, w_sb;

    always_comb begin
        w_sa    = i_operand_a;
        w_sb    = i_operand_b;
        w_add_x = {i_operand_a[31], i_operand_a} + {i_operand_b[31], i_operand_b};
        w_sub_x = {i_operand_a[31], i_operand_a} - {i_operand_b[31], i_operand_b};
        w_add   = w_add_x[31:0];
        w_sub   = w_sub_x[31:0];
        w_abs_a = i_operand_a[31] ? (~i_operand_a + 32'd1) : i_operand_a;
        w_abs_b = i_operand_b[31] ? (~i_operand_b + 32'd1) : i_operand_b;
        n_ctrl.mode         = fpa_pkg::t_mode'(i_mode);
        n_ctrl.a_less       = w_sa < w_sb;
        n_ctrl.a_equal      = i_operand_a == i_operand_b;
        n_ctrl.a_greater    = w_sa > w_sb;
        n_ctrl.b_zero       = i_operand_b == 32'd0;
        n_ctrl.neg          = i_operand_a[31] ^ i_operand_b[31];
        n_ctrl.simple_fault = fpa_pkg::FAULT_NONE;
        n_ctrl.simple       = i_operand_a;
        n_num = {w_abs_a, {FRACTION_BITS{1'b0}}};
        n_den = w_abs_b;
        unique case (fpa_pkg::t_mode'(i_mode))
            fpa_pkg::MODE_ADD: begin
                if (w_add_x[32] != w_add_x[31]) begin
                    n_ctrl.simple       = w_add_x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    n_ctrl.simple_fault = fpa_pkg::FAULT_SAT;
                end else begin
                    n_ctrl.simple = w_add;
                end
            end
            fpa_pkg::MODE_SUB: begin
                if (w_sub_x[32] != w_sub_x[31]) begin
                    n_ctrl.simple       = w_sub_x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    n_ctrl.simple_fault = fpa_pkg::FAULT_SAT;
                end else begin
                    n_ctrl.simple = w_sub;
                end
            end
            fpa_pkg::MODE_MIN: n_ctrl.simple = (w_sa > w_sb) ? i_operand_b : i_operand_a;
            fpa_pkg::MODE_MAX: n_ctrl.simple = (w_sa < w_sb) ? i_operand_b : i_operand_a;
            fpa_pkg::MODE_INC: n_ctrl.simple = i_operand_a + 32'd1;
            fpa_pkg::MODE_DEC: n_ctrl.simple = i_operand_a - 32'd1;
            default:           n_ctrl.simple = i_operand_a;
        endcase
    end

    // stage 1 registers: magnitudes for multiplier and divider
    logic [31:0]     r_abs_a, r_abs_b;
    logic [NumW-1:0] r_num;
    logic [31:0]     r_den;
    fpa_pkg::t_ctrl  r_ctrl1;
    logic            r_v1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
        end
        if (w_adv) begin
            r_ctrl1 <= n_ctrl;
            r_num   <= n_num;
            r_den   <= n_den;
            r_abs_a <= w_abs_a;
            r_abs_b <= w_abs_b;
        end
    end

    // divider array
    logic [NumW-1:0] w_quo;
    fpa_div #(.NumW(NumW), .DenW(32)) u_div (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (w_quo)
    );

    // multiplier: two 32x16 partial products, then add, then delay line
    logic [47:0]    r_pp_lo, r_pp_hi;
    logic [63:0]    r_prod;
    logic [63:0]    r_pd [NumW-1];
    fpa_pkg::t_ctrl r_cd [NumW+1];
    logic           r_vd [NumW+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pp_lo <= r_abs_a * {16'd0, r_abs_b[15:0]};
            r_pp_hi <= r_abs_a * {16'd0, r_abs_b[31:16]};
            r_prod  <= {16'd0, r_pp_lo} + {r_pp_hi, 16'd0};
            r_pd[0] <= r_prod;
            for (int k = 1; k < NumW - 1; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
            r_cd[0] <= r_ctrl1;
            for (int k = 1; k < NumW + 1; k++) begin
                r_cd[k] <= r_cd[k-1];
            end
        end
        if (!i_rst_n) begin
            for (int k = 0; k < NumW + 1; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vd[0] <= r_v1;
            for (int k = 1; k < NumW + 1; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    // final stage: scale, sign, saturate, select
    fpa_pkg::t_ctrl w_c;
    logic [63:0]    w_mag_m;
    logic [63:0]    w_mag;
    logic [31:0]    n_res;
    logic [1:0]     n_fault;

    assign w_c = r_cd[NumW];

    always_comb begin
        w_mag_m = r_pd[NumW-2] >> FRACTION_BITS;
        w_mag   = (w_c.mode == fpa_pkg::MODE_MUL) ? w_mag_m
                                                  : {{(64-NumW){1'b0}}, w_quo};
        n_res   = w_c.simple;
        n_fault = w_c.simple_fault;
        if (w_c.mode == fpa_pkg::MODE_MUL || w_c.mode == fpa_pkg::MODE_DIV) begin
            n_fault = fpa_pkg::FAULT_NONE;
            if (w_c.mode == fpa_pkg::MODE_DIV && w_c.b_zero) begin
                n_res   = 32'd0;
                n_fault = fpa_pkg::FAULT_DIV0;
            end else if (w_c.neg) begin
                if (w_mag > 64'h8000_0000) begin
                    n_res   = 32'h8000_0000;
                    n_fault = fpa_pkg::FAULT_SAT;
                end else begin
                    n_res = ~w_mag[31:0] + 32'd1;
                end
            end else begin
                if (w_mag > 64'h7FFF_FFFF) begin
                    n_res   = 32'h7FFF_FFFF;
                    n_fault = fpa_pkg::FAULT_SAT;
                end else begin
                    n_res = w_mag[31:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r_vd[NumW];
        end
        if (w_adv) begin
            o_result    <= n_res;
            o_fault     <= n_fault;
            o_a_less    <= w_c.a_less;
            o_a_equal   <= w_c.a_equal;
            o_a_greater <= w_c.a_greater;
        end
    end
endmodule
`default_nettype wire
